[rtl/ordered_list_remove_by_value_top_macros.svh]
// Assertion macros shared by the ordered list RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ORDERED_LIST_REMOVE_BY_VALUE_TOP_MACROS_SVH
`define ORDERED_LIST_REMOVE_BY_VALUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OLRBV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define OLRBV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/olrbv_pkg.sv]
// Shared types and codes for the ordered list block.
// No dependencies.
package olrbv_pkg;

	// Command codes on the request channel
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_ENTRY    = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic       capture;    // register the match vector for a remove
		logic       append;     // write value at the tail
		logic       shift;      // close the gap at the first match
		logic       dump_start; // clear the dump index
		logic       rotate;     // rotate list one place, head goes to tail
		logic       load;       // load the output register
		logic       use_head;   // output value comes from the head entry
		logic       last;       // final result of this request
		logic [2:0] st;         // status code for the result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic found;
		logic dump_last;
	} dp_stat_t;

endpackage

[rtl/olrbv_ctrl.sv]
// Request sequencer for the ordered list: handshakes and command generation.
// Depends on olrbv_pkg and ordered_list_remove_by_value_top_macros.svh.
`include "ordered_list_remove_by_value_top_macros.svh"

module olrbv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output olrbv_pkg::dp_cmd_t  cmd_o,
	input  olrbv_pkg::dp_stat_t stat_i
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_DUMP
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   acc;

	// Output slot is free if empty or being taken this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		cmd_o   = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						olrbv_pkg::CMD_APPEND: begin
							cmd_o.append = !stat_i.full;
							cmd_o.load   = 1'b1;
							cmd_o.last   = 1'b1;
							cmd_o.st     = stat_i.full ? olrbv_pkg::ST_FULL : olrbv_pkg::ST_OK;
						end
						olrbv_pkg::CMD_REMOVE: begin
							cmd_o.capture = 1'b1;
							state_d       = ST_REMOVE;
						end
						olrbv_pkg::CMD_DUMP: begin
							if (stat_i.empty) begin
								cmd_o.load = 1'b1;
								cmd_o.last = 1'b1;
								cmd_o.st   = olrbv_pkg::ST_EMPTY;
							end else begin
								cmd_o.dump_start = 1'b1;
								state_d          = ST_DUMP;
							end
						end
						default: ; // unused code: dropped
					endcase
				end
			end
			ST_REMOVE: begin
				cmd_o.shift = stat_i.found;
				cmd_o.load  = 1'b1;
				cmd_o.last  = 1'b1;
				cmd_o.st    = stat_i.found ? olrbv_pkg::ST_OK : olrbv_pkg::ST_NOTFOUND;
				state_d     = ST_IDLE;
			end
			ST_DUMP: begin
				if (out_free) begin
					cmd_o.load     = 1'b1;
					cmd_o.use_head = 1'b1;
					cmd_o.rotate   = 1'b1;
					cmd_o.last     = stat_i.dump_last;
					cmd_o.st       = olrbv_pkg::ST_ENTRY;
					if (stat_i.dump_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_o.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`OLRBV_ASSERT_IMP(a_no_overrun, cmd_o.load, !(out_valid_q && out_stall), "result overwritten")
	`OLRBV_ASSERT_NXT(a_remove_one, state_q == ST_REMOVE, state_q == ST_IDLE, "remove overran")
	`OLRBV_ASSERT_NXT(a_dump_end, (state_q == ST_DUMP) && cmd_o.load && cmd_o.last, state_q == ST_IDLE, "dump did not end")

endmodule

[rtl/olrbv_dp.sv]
// Datapath for the ordered list: entry registers, compare, shift, rotate, result register.
// Depends on olrbv_pkg and ordered_list_remove_by_value_top_macros.svh.
`include "ordered_list_remove_by_value_top_macros.svh"

module olrbv_dp #(
	parameter int DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  olrbv_pkg::dp_cmd_t  cmd_i,
	output olrbv_pkg::dp_stat_t stat_o,
	input  logic [31:0]         value,
	output logic [2:0]          status,
	output logic signed [31:0]  entry_value,
	output logic [5:0]          entry_count,
	output logic                last
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [31:0]     ent_q [DEPTH];
	logic [31:0]     ent_d [DEPTH];
	logic [DEPTH-1:0] match_q, match_d;
	logic [DEPTH-1:0] sh_en;
	logic [CntW-1:0] cnt_q, cnt_d, cnt_m1;
	logic [CntW-1:0] idx_q;
	logic [2:0]      status_q;
	logic [31:0]     val_q;
	logic [5:0]      count_q;
	logic            last_q;

	assign cnt_m1 = cnt_q - CntW'(1);

	// Per-entry compare against the request value, live entries only
	for (genvar g = 0; g < DEPTH; g++) begin : g_cmp
		assign match_d[g] = (ent_q[g] == value) && (CntW'(g) < cnt_q);
		// entry moves up if the first match is at or below it
		assign sh_en[g]   = |match_q[g:0];
	end

	// Next entry values: append, gap close or dump rotation
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_d[i] = ent_q[i];
			if (cmd_i.append && (CntW'(i) == cnt_q)) begin
				ent_d[i] = value;
			end else if (cmd_i.shift && sh_en[i]) begin
				ent_d[i] = ent_q[(i + 1) % DEPTH];
			end else if (cmd_i.rotate) begin
				ent_d[i] = (CntW'(i) == cnt_m1) ? ent_q[0] : ent_q[(i + 1) % DEPTH];
			end
		end
	end

	// Entry count update
	always_comb begin
		cnt_d = cnt_q;
		if (cmd_i.append) begin
			cnt_d = cnt_q + CntW'(1);
		end else if (cmd_i.shift) begin
			cnt_d = cnt_m1;
		end
	end

	// Entry storage, no reset
	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			match_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd_i.capture) begin
				match_q <= match_d;
			end
			if (cmd_i.dump_start) begin
				idx_q <= '0;
			end else if (cmd_i.rotate) begin
				idx_q <= idx_q + CntW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			status_q <= cmd_i.st;
			val_q    <= cmd_i.use_head ? ent_q[0] : '0;
			count_q  <= 6'(cnt_d);
			last_q   <= cmd_i.last;
		end
	end

	assign status      = status_q;
	assign entry_value = val_q;
	assign entry_count = count_q;
	assign last        = last_q;

	assign stat_o.full      = (cnt_q == CntW'(DEPTH));
	assign stat_o.empty     = (cnt_q == '0);
	assign stat_o.found     = |match_q;
	assign stat_o.dump_last = (idx_q == cnt_m1);

	`OLRBV_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(DEPTH), "count above depth")
	`OLRBV_ASSERT_IMP(a_shift_found, cmd_i.shift, |match_q, "gap close without a match")
	`OLRBV_ASSERT_NXT(a_dump_idx, cmd_i.dump_start, idx_q == '0, "dump index not cleared")

endmodule

[rtl/ordered_list_remove_by_value_top.sv]
// Ordered list of signed identifiers with append, remove by value and dump.
// Each request occupies the block alone: an append, an unused code or a dump of an
// empty list is handled when accepted, a remove compares all entries in parallel
// into a match register and then closes the gap, and a dump clears its index, then
// sends one entry per cycle while the output is free, each waiting on the single
// output register that the rotating entry file feeds from its head, so a stalled
// output stretches the dump. A new request is taken while the previous result
// still sits in the output register, provided that result is taken in the same
// cycle. Entries past the tail are never read, so the entry registers have no reset.
// Depends on olrbv_pkg, olrbv_ctrl and olrbv_dp.
module ordered_list_remove_by_value_top #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] entry_value,
	output logic [5:0]         entry_count,
	output logic               last
);

	olrbv_pkg::dp_cmd_t  dp_cmd;
	olrbv_pkg::dp_stat_t dp_stat;

	// Request sequencing
	olrbv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd_o     (dp_cmd),
		.stat_i    (dp_stat)
	);

	// Entry file and result register
	olrbv_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_i       (dp_cmd),
		.stat_o      (dp_stat),
		.value       (value),
		.status      (status),
		.entry_value (entry_value),
		.entry_count (entry_count),
		.last        (last)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_remove_by_value_top: predicts every result.
// Uses olrbv_pkg for command and status codes and the top module of the ordered list.
module tb_top;

	localparam int DEPTH = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 80;
	localparam int LONG_HOLD = 150;
	localparam int RAND_ITEMS = 95;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] val;
		bit                 wait_idle;  // hold back until every result is back
	} list_req_t;

	typedef struct {
		logic [2:0]         st;
		logic signed [31:0] ev;
		logic [5:0]         cnt;
		logic               lst;
	} list_resp_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = olrbv_pkg::CMD_APPEND;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] entry_value;
	logic [5:0]         entry_count;
	logic               last;

	list_req_t          req_q[$];       // requests still to be sent
	list_resp_t         want_q[$];      // predicted results, oldest first
	logic signed [31:0] list_model[$];  // predicted list contents, head first
	logic signed [31:0] gen_list[$];    // list as the stimulus generator sees it

	int n_err = 0;
	int n_sent = 0;
	int n_recv = 0;
	int n_dumps = 0;
	int n_full = 0;
	int n_miss = 0;

	ordered_list_remove_by_value_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_value(entry_value),
		.entry_count(entry_count),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pause length: mostly none, some short, a few long; calm runs with none at all
	function automatic int pick_pause(inout int calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (r < 4) begin
			calm = 25;
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic push_resp(input logic [2:0] st, input logic signed [31:0] ev,
		input logic lst);
		list_resp_t r;
		r.st = st;
		r.ev = ev;
		r.cnt = 6'(list_model.size());
		r.lst = lst;
		want_q.push_back(r);
	endtask

	// Predict the results of one accepted request and update the list model
	task automatic apply_list_cmd(input logic [1:0] op, input logic signed [31:0] v);
		int idx;
		idx = -1;
		case (op)
		olrbv_pkg::CMD_APPEND: begin
			if (list_model.size() >= DEPTH) begin
				n_full++;
				push_resp(olrbv_pkg::ST_FULL, '0, 1'b1);
			end else begin
				list_model.push_back(v);
				push_resp(olrbv_pkg::ST_OK, '0, 1'b1);
			end
		end
		olrbv_pkg::CMD_REMOVE: begin
			// only the match nearest the head goes
			for (int i = 0; i < list_model.size(); i++) begin
				if (idx < 0 && list_model[i] == v)
					idx = i;
			end
			if (idx < 0) begin
				n_miss++;
				push_resp(olrbv_pkg::ST_NOTFOUND, '0, 1'b1);
			end else begin
				list_model.delete(idx);
				push_resp(olrbv_pkg::ST_OK, '0, 1'b1);
			end
		end
		olrbv_pkg::CMD_DUMP: begin
			n_dumps++;
			if (list_model.size() == 0)
				push_resp(olrbv_pkg::ST_EMPTY, '0, 1'b1);
			else
				for (int i = 0; i < list_model.size(); i++)
					push_resp(olrbv_pkg::ST_ENTRY, list_model[i],
						i == list_model.size() - 1);
		end
		default: ;  // unused code: no result, no change
		endcase
	endtask

	// Queue a request and track what the list will hold
	task automatic add_req(input logic [1:0] op, input logic signed [31:0] v,
		input bit hold);
		list_req_t q;
		int idx;
		idx = -1;
		q.op = op;
		q.val = v;
		q.wait_idle = hold;
		req_q.push_back(q);
		if (op == olrbv_pkg::CMD_APPEND && gen_list.size() < DEPTH)
			gen_list.push_back(v);
		if (op == olrbv_pkg::CMD_REMOVE) begin
			for (int i = 0; i < gen_list.size(); i++)
				if (idx < 0 && gen_list[i] == v)
					idx = i;
			if (idx >= 0)
				gen_list.delete(idx);
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 1))
			return $signed($urandom_range(0, 15)) - 8;
		return $urandom;
	endfunction

	function automatic logic signed [31:0] pick_present();
		if (gen_list.size() == 0)
			return $urandom;
		return gen_list[$urandom_range(0, gen_list.size() - 1)];
	endfunction

	// Fill the list to capacity, overflow it, dump it, then work at the full mark
	task automatic fill_burst(inout int n);
		while (gen_list.size() < DEPTH) begin
			add_req(olrbv_pkg::CMD_APPEND, pick_value(), 1'b0);
			n++;
		end
		add_req(olrbv_pkg::CMD_APPEND, pick_value(), 1'b0);
		add_req(olrbv_pkg::CMD_DUMP, $urandom, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, pick_present(), 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, pick_value(), 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, pick_value(), 1'b0);
		n += 5;
	endtask

	// Request driver
	int tx_gap = 0;
	int tx_calm = 0;
	list_req_t tx_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= olrbv_pkg::CMD_APPEND;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_list_cmd(cmd, value);
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (req_q.size() > 0 && (!req_q[0].wait_idle || want_q.size() == 0)) begin
					tx_req = req_q.pop_front();
					in_valid <= 1'b1;
					cmd <= tx_req.op;
					value <= tx_req.val;
					tx_gap = pick_pause(tx_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator
	int rx_hold = 0;
	int rx_calm = 0;
	bit long_done = 0;
	int rx_len;
	list_resp_t got;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_recv++;
				if (want_q.size() == 0) begin
					$error("unexpected result: status %0d value %0d count %0d last %0b",
						status, entry_value, entry_count, last);
					n_err++;
				end else begin
					got = want_q.pop_front();
					if (status !== got.st) begin
						$error("status: expected %0d, got %0d", got.st, status);
						n_err++;
					end
					if (entry_value !== got.ev) begin
						$error("entry_value: expected %0d, got %0d", got.ev, entry_value);
						n_err++;
					end
					if (entry_count !== got.cnt) begin
						$error("entry_count: expected %0d, got %0d", got.cnt, entry_count);
						n_err++;
					end
					if (last !== got.lst) begin
						$error("last: expected %0b, got %0b", got.lst, last);
						n_err++;
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (!long_done && n_recv >= 40) begin
				// long hold-off so the block backs up into its input
				long_done = 1;
				rx_hold = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				rx_len = pick_pause(rx_calm);
				if (rx_len > 0) begin
					rx_hold = rx_len - 1;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int n;
		int r;
		n = 0;

		// directed: empty cases, field extremes, duplicates, absent value, unused code
		add_req(olrbv_pkg::CMD_DUMP, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sh8000_0000, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sh7fff_ffff, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, -32'sd1, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sd5, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sd5, 1'b0);
		add_req(olrbv_pkg::CMD_APPEND, 32'sd9, 1'b0);
		add_req(olrbv_pkg::CMD_DUMP, -32'sd1, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd5, 1'b0);
		add_req(olrbv_pkg::CMD_DUMP, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd1234, 1'b1);
		add_req(CMD_UNUSED, -32'sd1, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sh8000_0000, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd9, 1'b0);
		add_req(olrbv_pkg::CMD_DUMP, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sh7fff_ffff, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd0, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, -32'sd1, 1'b0);
		add_req(olrbv_pkg::CMD_REMOVE, 32'sd5, 1'b0);
		add_req(olrbv_pkg::CMD_DUMP, 32'sd0, 1'b0);
		add_req(CMD_UNUSED, 32'sd0, 1'b0);

		// random: first a pause for a full drain, one fill to capacity, then a mix
		add_req(olrbv_pkg::CMD_APPEND, pick_value(), 1'b1);
		n++;
		fill_burst(n);
		while (n < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				fill_burst(n);
			end else if (r < 38) begin
				add_req(olrbv_pkg::CMD_APPEND, pick_value(), $urandom_range(0, 29) == 0);
				n++;
			end else if (r < 68) begin
				add_req(olrbv_pkg::CMD_REMOVE, pick_present(), 1'b0);
				n++;
			end else if (r < 78) begin
				add_req(olrbv_pkg::CMD_REMOVE, pick_value(), 1'b0);
				n++;
			end else if (r < 94) begin
				add_req(olrbv_pkg::CMD_DUMP, $urandom, 1'b0);
				n++;
			end else begin
				add_req(CMD_UNUSED, $urandom, 1'b0);
			end
		end
		add_req(olrbv_pkg::CMD_DUMP, 32'sd0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || in_valid || want_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (want_q.size() != 0) begin
			$error("%0d expected results never arrived", want_q.size());
			n_err++;
		end
		$display("Covered %0d requests: %0d dumps, %0d appends on a full list, %0d misses.",
			n_sent, n_dumps, n_full, n_miss);
		$display("Checked %0d results under random gaps, stalls and one long hold-off.",
			n_recv);
		if (n_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/olrbv_pkg.sv
rtl/olrbv_ctrl.sv
rtl/olrbv_dp.sv
rtl/ordered_list_remove_by_value_top.sv
test/tb_top.sv
